// File: rtl/rar_pkg.sv
// Shared widths, opcodes and status codes for the rational arithmetic unit.
package rar_pkg;

    localparam int FIELD_W = 16;
    localparam int MAG_W   = 48;
    localparam int NUM_W   = 32;
    localparam int DEN_W   = 31;

    localparam logic [1:0] OP_ADD   = 2'd0;
    localparam logic [1:0] OP_SUB   = 2'd1;
    localparam logic [1:0] OP_MUL   = 2'd2;
    localparam logic [1:0] OP_WHOLE = 2'd3;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_ZERO_DEN = 2'd1;
    localparam logic [1:0] ST_OVF      = 2'd2;

endpackage

// File: rtl/rar_reduce.sv
// Binary GCD and bit-serial division of both magnitudes by the GCD.
module rar_reduce #(
    parameter int MagW = rar_pkg::MAG_W
) (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            start,
    input  logic [MagW-1:0] un,
    input  logic [MagW-1:0] ud,
    output logic            done,
    output logic [MagW-1:0] qn,
    output logic [MagW-1:0] qd
);

    localparam int CntW = $clog2(MagW);
    localparam logic [1:0] R_IDLE = 2'd0;
    localparam logic [1:0] R_TWO  = 2'd1;
    localparam logic [1:0] R_LOOP = 2'd2;
    localparam logic [1:0] R_DIV  = 2'd3;

    logic [1:0]      state_reg, state_next;
    logic [MagW-1:0] ga_reg, ga_next, gb_reg, gb_next;
    logic [MagW-1:0] xn_reg, xn_next, xd_reg, xd_next;
    logic [MagW-1:0] rn_reg, rn_next, rd_reg, rd_next;
    logic [MagW-1:0] qn_reg, qn_next, qd_reg, qd_next;
    logic [CntW-1:0] cnt_reg, cnt_next;
    logic            done_reg, done_next;
    logic [MagW:0]   diff, tn, td;

    always_comb begin
        state_next = state_reg;
        ga_next    = ga_reg;
        gb_next    = gb_reg;
        xn_next    = xn_reg;
        xd_next    = xd_reg;
        rn_next    = rn_reg;
        rd_next    = rd_reg;
        qn_next    = qn_reg;
        qd_next    = qd_reg;
        cnt_next   = cnt_reg;
        done_next  = 1'b0;
        diff       = {1'b0, ga_reg} - {1'b0, gb_reg};
        tn         = {rn_reg, xn_reg[MagW-1]};
        td         = {rd_reg, xd_reg[MagW-1]};
        case (state_reg)
            R_IDLE: begin
                if (start) begin
                    ga_next    = un;
                    gb_next    = ud;
                    state_next = R_TWO;
                end
            end
            R_TWO: begin
                // strip common factors of two; the shifted copies become the dividends
                if (!ga_reg[0] && !gb_reg[0]) begin
                    ga_next = ga_reg >> 1;
                    gb_next = gb_reg >> 1;
                end else begin
                    xn_next    = ga_reg;
                    xd_next    = gb_reg;
                    state_next = R_LOOP;
                end
            end
            R_LOOP: begin
                if (gb_reg == '0) begin
                    rn_next    = '0;
                    rd_next    = '0;
                    cnt_next   = '0;
                    state_next = R_DIV;
                end else if (!ga_reg[0]) begin
                    ga_next = ga_reg >> 1;
                end else if (!gb_reg[0]) begin
                    gb_next = gb_reg >> 1;
                end else if (diff[MagW]) begin
                    gb_next = gb_reg - ga_reg;
                end else begin
                    ga_next = gb_reg;
                    gb_next = diff[MagW-1:0];
                end
            end
            R_DIV: begin
                // restoring division, one quotient bit per cycle on both sides
                if (tn >= {1'b0, ga_reg}) begin
                    rn_next = MagW'(tn - {1'b0, ga_reg});
                    qn_next = {qn_reg[MagW-2:0], 1'b1};
                end else begin
                    rn_next = tn[MagW-1:0];
                    qn_next = {qn_reg[MagW-2:0], 1'b0};
                end
                if (td >= {1'b0, ga_reg}) begin
                    rd_next = MagW'(td - {1'b0, ga_reg});
                    qd_next = {qd_reg[MagW-2:0], 1'b1};
                end else begin
                    rd_next = td[MagW-1:0];
                    qd_next = {qd_reg[MagW-2:0], 1'b0};
                end
                xn_next  = xn_reg << 1;
                xd_next  = xd_reg << 1;
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == CntW'(MagW - 1)) begin
                    done_next  = 1'b1;
                    state_next = R_IDLE;
                end
            end
            default: state_next = R_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= R_IDLE;
            done_reg  <= 1'b0;
            cnt_reg   <= '0;
        end else begin
            state_reg <= state_next;
            done_reg  <= done_next;
            cnt_reg   <= cnt_next;
        end
        ga_reg <= ga_next;
        gb_reg <= gb_next;
        xn_reg <= xn_next;
        xd_reg <= xd_next;
        rn_reg <= rn_next;
        rd_reg <= rd_next;
        qn_reg <= qn_next;
        qd_reg <= qd_next;
    end

    assign done = done_reg;
    assign qn   = qn_reg;
    assign qd   = qd_reg;

endmodule

// File: rtl/rational_arith_reduce.sv
// Rational arithmetic unit: serial products, binary GCD reduction, stored fraction.
// Steps: check, then zero to three serial products, combine, binary GCD reduction
//   and division of both magnitudes by the GCD, then output; a zero denominator
//   goes from the check straight to the output, a zero numerator skips the reduction.
// Throughput: one request at a time; the next is taken once the result sits in
//   the output register. The GCD loop and the 48-bit serial divider set the pace.
// Reset (aresetn low, synchronous): idle, no result pending, stored fraction 0/1.
module rational_arith_reduce (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [79:0] s_tdata,  // lhs_num, lhs_den, rhs_num, rhs_den, whole_addend
    input  logic [1:0]  s_tuser,  // opcode
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [63:0] m_tdata,  // result_num, result_den, zero pad
    output logic [1:0]  m_tuser   // status
);

    localparam int MW = rar_pkg::MAG_W;
    localparam int FW = rar_pkg::FIELD_W;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_CHECK = 3'd1;
    localparam logic [2:0] S_LOAD  = 3'd2;
    localparam logic [2:0] S_MUL   = 3'd3;
    localparam logic [2:0] S_COMB  = 3'd4;
    localparam logic [2:0] S_RED   = 3'd5;
    localparam logic [2:0] S_OUT   = 3'd6;

    logic [2:0] state_reg, state_next;

    // captured request
    logic [1:0]           op_reg;
    logic signed [FW-1:0] a_reg, b_reg, c_reg, d_reg, w_reg;

    // stored fraction, denominator always positive
    logic signed [rar_pkg::NUM_W-1:0] sn_reg, sn_next;
    logic [rar_pkg::DEN_W-1:0]        sd_reg, sd_next;

    // serial multiplier: one multiplier bit per cycle
    logic [MW-2:0] mc_reg, mc_next, prod_reg, prod_next;
    logic [FW-1:0] mp_reg, mp_next;
    logic [3:0]    mcnt_reg, mcnt_next;
    logic          mneg_reg, mneg_next;
    logic [1:0]    k_reg, k_next;
    logic [1:0]    njobs;
    logic signed [MW-1:0] p0_reg, p1_reg, p2_reg, p0_next, p1_next, p2_next;
    logic signed [MW-1:0] prod_s;
    logic signed [31:0]   x_op;
    logic signed [FW-1:0] y_op;
    logic [31:0]          x_mag;
    logic [FW-1:0]        y_mag;

    // combine and reduce
    logic signed [MW-1:0] num_c, den_c;
    logic [MW-1:0]        num_mag, den_mag, qn, qd;
    logic                 neg_reg, neg_next, red_start, red_done, ovf;

    // result staging and output register
    logic [rar_pkg::NUM_W-1:0] res_num_reg, res_num_next, rnum_c;
    logic [rar_pkg::DEN_W-1:0] res_den_reg, res_den_next;
    logic [1:0]                res_st_reg, res_st_next;
    logic                      m_tvalid_reg, m_tvalid_next;
    logic [63:0]               m_tdata_reg, m_tdata_next;
    logic [1:0]                m_tuser_reg, m_tuser_next;

    logic s_acc;
    assign s_acc    = s_tvalid && s_tready;
    assign s_tready = (state_reg == S_IDLE);

    // products needed: multiply 2, whole 1, add/sub with a shared denominator none, else 3
    always_comb begin
        case (op_reg)
            rar_pkg::OP_MUL:   njobs = 2'd2;
            rar_pkg::OP_WHOLE: njobs = 2'd1;
            default:           njobs = (b_reg == d_reg) ? 2'd0 : 2'd3;
        endcase
    end

    // operand pair for product k
    always_comb begin
        x_op = 32'(a_reg);
        y_op = d_reg;
        case (op_reg)
            rar_pkg::OP_MUL: begin
                x_op = (k_reg == 2'd0) ? 32'(a_reg) : 32'(b_reg);
                y_op = (k_reg == 2'd0) ? c_reg : d_reg;
            end
            rar_pkg::OP_WHOLE: begin
                x_op = {1'b0, sd_reg};
                y_op = w_reg;
            end
            default: begin
                case (k_reg)
                    2'd0:    begin x_op = 32'(a_reg); y_op = d_reg; end
                    2'd1:    begin x_op = 32'(c_reg); y_op = b_reg; end
                    default: begin x_op = 32'(b_reg); y_op = d_reg; end
                endcase
            end
        endcase
        x_mag = x_op[31] ? 32'd0 - 32'(x_op) : 32'(x_op);
        y_mag = y_op[FW-1] ? FW'(0) - FW'(y_op) : FW'(y_op);
    end

    // exact numerator and denominator before reduction
    always_comb begin
        case (op_reg)
            rar_pkg::OP_MUL: begin
                num_c = p0_reg;
                den_c = p1_reg;
            end
            rar_pkg::OP_WHOLE: begin
                num_c = MW'(sn_reg) + p0_reg;
                den_c = MW'({1'b0, sd_reg});
            end
            default: begin
                if (b_reg == d_reg) begin
                    num_c = (op_reg == rar_pkg::OP_ADD) ? MW'(a_reg) + MW'(c_reg)
                                                        : MW'(a_reg) - MW'(c_reg);
                    den_c = MW'(b_reg);
                end else begin
                    num_c = (op_reg == rar_pkg::OP_ADD) ? p0_reg + p1_reg : p0_reg - p1_reg;
                    den_c = p2_reg;
                end
            end
        endcase
        num_mag = num_c[MW-1] ? MW'(0) - MW'(num_c) : MW'(num_c);
        den_mag = den_c[MW-1] ? MW'(0) - MW'(den_c) : MW'(den_c);
    end

    assign red_start = (state_reg == S_COMB) && (num_c != '0);

    rar_reduce #(.MagW(MW)) u_reduce (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (red_start),
        .un      (num_mag),
        .ud      (den_mag),
        .done    (red_done),
        .qn      (qn),
        .qd      (qd)
    );

    assign ovf = (qd > MW'(32'h7FFF_FFFF)) ||
                 (!neg_reg && qn > MW'(32'h7FFF_FFFF)) ||
                 (neg_reg && qn > MW'(32'h8000_0000));
    assign rnum_c = neg_reg ? 32'd0 - qn[31:0] : qn[31:0];

    assign prod_next = mp_reg[0] ? prod_reg + mc_reg : prod_reg;
    assign prod_s    = mneg_reg ? MW'(0) - {1'b0, prod_next} : {1'b0, prod_next};

    always_comb begin
        state_next    = state_reg;
        sn_next       = sn_reg;
        sd_next       = sd_reg;
        mc_next       = mc_reg;
        mp_next       = mp_reg;
        mcnt_next     = mcnt_reg;
        mneg_next     = mneg_reg;
        k_next        = k_reg;
        p0_next       = p0_reg;
        p1_next       = p1_reg;
        p2_next       = p2_reg;
        neg_next      = neg_reg;
        res_num_next  = res_num_reg;
        res_den_next  = res_den_reg;
        res_st_next   = res_st_reg;
        m_tvalid_next = m_tvalid_reg && !m_tready;
        m_tdata_next  = m_tdata_reg;
        m_tuser_next  = m_tuser_reg;
        case (state_reg)
            S_IDLE: begin
                if (s_acc) state_next = S_CHECK;
            end
            S_CHECK: begin
                k_next = 2'd0;
                if (op_reg != rar_pkg::OP_WHOLE && (b_reg == '0 || d_reg == '0)) begin
                    res_num_next = '0;
                    res_den_next = '0;
                    res_st_next  = rar_pkg::ST_ZERO_DEN;
                    state_next   = S_OUT;
                end else if (njobs == 2'd0) begin
                    state_next = S_COMB;
                end else begin
                    state_next = S_LOAD;
                end
            end
            S_LOAD: begin
                mc_next    = (MW-1)'(x_mag);
                mp_next    = y_mag;
                mneg_next  = x_op[31] ^ y_op[FW-1];
                mcnt_next  = '0;
                state_next = S_MUL;
            end
            S_MUL: begin
                // shift-add; products go to p0..p2 in order
                mc_next   = mc_reg << 1;
                mp_next   = mp_reg >> 1;
                mcnt_next = mcnt_reg + 1'b1;
                if (mcnt_reg == 4'(FW - 1)) begin
                    case (k_reg)
                        2'd0:    p0_next = prod_s;
                        2'd1:    p1_next = prod_s;
                        default: p2_next = prod_s;
                    endcase
                    k_next     = k_reg + 1'b1;
                    state_next = (k_reg + 1'b1 == njobs) ? S_COMB : S_LOAD;
                end
            end
            S_COMB: begin
                neg_next = num_c[MW-1] ^ den_c[MW-1];
                if (num_c == '0) begin
                    res_num_next = '0;
                    res_den_next = rar_pkg::DEN_W'(1);
                    res_st_next  = rar_pkg::ST_OK;
                    state_next   = S_OUT;
                end else begin
                    state_next = S_RED;
                end
            end
            S_RED: begin
                if (red_done) begin
                    if (ovf) begin
                        res_num_next = '0;
                        res_den_next = '0;
                        res_st_next  = rar_pkg::ST_OVF;
                    end else begin
                        res_num_next = rnum_c;
                        res_den_next = qd[rar_pkg::DEN_W-1:0];
                        res_st_next  = rar_pkg::ST_OK;
                    end
                    state_next = S_OUT;
                end
            end
            S_OUT: begin
                // hand over once the output register is free; good results are kept
                if (!m_tvalid_reg || m_tready) begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = {1'b0, res_den_reg, res_num_reg};
                    m_tuser_next  = res_st_reg;
                    if (res_st_reg == rar_pkg::ST_OK) begin
                        sn_next = res_num_reg;
                        sd_next = res_den_reg;
                    end
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            m_tvalid_reg <= 1'b0;
            sn_reg       <= '0;
            sd_reg       <= rar_pkg::DEN_W'(1);
            k_reg        <= '0;
            mcnt_reg     <= '0;
        end else begin
            state_reg    <= state_next;
            m_tvalid_reg <= m_tvalid_next;
            sn_reg       <= sn_next;
            sd_reg       <= sd_next;
            k_reg        <= k_next;
            mcnt_reg     <= mcnt_next;
        end
        if (s_acc) begin
            op_reg <= s_tuser;
            a_reg  <= s_tdata[15:0];
            b_reg  <= s_tdata[31:16];
            c_reg  <= s_tdata[47:32];
            d_reg  <= s_tdata[63:48];
            w_reg  <= s_tdata[79:64];
        end
        mc_reg      <= mc_next;
        mp_reg      <= mp_next;
        prod_reg    <= (state_reg == S_LOAD) ? '0 : prod_next;
        mneg_reg    <= mneg_next;
        p0_reg      <= p0_next;
        p1_reg      <= p1_next;
        p2_reg      <= p2_next;
        neg_reg     <= neg_next;
        res_num_reg <= res_num_next;
        res_den_reg <= res_den_next;
        res_st_reg  <= res_st_next;
        m_tdata_reg <= m_tdata_next;
        m_tuser_reg <= m_tuser_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

endmodule

// File: rtl/rar_checker.sv
// Port-level checker for the rational arithmetic unit, bound to the top level.
module rar_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [63:0] m_tdata,
    input logic [1:0]  m_tuser
);

    a_reset_idle: assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

    a_one_at_a_time: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("second request taken while one is in work");

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tuser)))
        else $error("stalled result changed");

    a_err_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && (m_tuser == rar_pkg::ST_ZERO_DEN || m_tuser == rar_pkg::ST_OVF))
        |-> (m_tdata == 64'd0))
        else $error("error result not zero");

    a_ok_den: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser == rar_pkg::ST_OK) |-> (m_tdata[62:32] != 31'd0))
        else $error("good result with zero denominator");

endmodule

bind rational_arith_reduce rar_checker u_rar_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

// File: bench/tb.sv
// Testbench for rational_arith_reduce: random and directed requests against a predictor.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    // One expected result: numerator, denominator, status.
    typedef struct packed {
        logic [31:0] num;
        logic [30:0] den;
        logic [1:0]  st;
    } frac_res_t;

    // Fraction scoreboard: tracks the stored fraction and queues expected results.
    class frac_scoreboard;
        longint    held_num;
        longint    held_den;
        frac_res_t pending[$];
        int        errors;

        function new();
            held_num = 0;
            held_den = 1;
            errors   = 0;
        endfunction

        function longint gcd_abs(longint a, longint b);
            longint r;
            while (b != 0) begin
                r = a % b;
                a = b;
                b = r;
            end
            return a;
        endfunction

        // Work out the result of one accepted request.
        function void note_request(logic [1:0] op, logic [79:0] d);
            longint a, b, c, e, w, num, den, un, ud, g;
            bit neg;
            frac_res_t r;
            a = longint'($signed(d[15:0]));
            b = longint'($signed(d[31:16]));
            c = longint'($signed(d[47:32]));
            e = longint'($signed(d[63:48]));
            w = longint'($signed(d[79:64]));
            if (op == rar_pkg::OP_WHOLE) begin
                num = held_num + held_den * w;
                den = held_den;
            end else begin
                if (b == 0 || e == 0) begin
                    r = '{num: '0, den: '0, st: rar_pkg::ST_ZERO_DEN};
                    pending.push_back(r);
                    return;
                end
                if (op == rar_pkg::OP_MUL) begin
                    num = a * c;
                    den = b * e;
                end else if (b == e) begin
                    num = (op == rar_pkg::OP_ADD) ? a + c : a - c;
                    den = b;
                end else begin
                    num = (op == rar_pkg::OP_ADD) ? a * e + c * b : a * e - c * b;
                    den = b * e;
                end
            end
            if (num == 0) begin
                num = 0;
                den = 1;
            end else begin
                neg = (num < 0) != (den < 0);
                un  = num < 0 ? -num : num;
                ud  = den < 0 ? -den : den;
                g   = gcd_abs(un, ud);
                un  = un / g;
                ud  = ud / g;
                if (ud > 64'sd2147483647 || (!neg && un > 64'sd2147483647) ||
                    (neg && un > 64'sd2147483648)) begin
                    r = '{num: '0, den: '0, st: rar_pkg::ST_OVF};
                    pending.push_back(r);
                    return;
                end
                den = ud;
                num = neg ? -un : un;
            end
            held_num = num;
            held_den = den;
            r = '{num: num[31:0], den: den[30:0], st: rar_pkg::ST_OK};
            pending.push_back(r);
        endfunction

        // Compare one accepted result with the oldest expectation.
        function void check_result(logic [63:0] d, logic [1:0] st);
            frac_res_t x;
            if (pending.size() == 0) begin
                errors++;
                if (errors <= 10) $display("unexpected result num=%0d", $signed(d[31:0]));
                return;
            end
            x = pending.pop_front();
            if (d[31:0] !== x.num || d[62:32] !== x.den || st !== x.st) begin
                errors++;
                if (errors <= 10)
                    $display("mismatch: exp %0d/%0d st%0d, got %0d/%0d st%0d",
                             $signed(x.num), x.den, x.st,
                             $signed(d[31:0]), d[62:32], st);
            end
        endfunction
    endclass

    logic        aclk = 0;
    logic        aresetn = 0;
    logic        s_tvalid = 0;
    logic        s_tready;
    logic [79:0] s_tdata = '0;
    logic [1:0]  s_tuser = '0;
    logic        m_tvalid;
    logic        m_tready = 0;
    logic [63:0] m_tdata;
    logic [1:0]  m_tuser;

    frac_scoreboard sb = new();
    int  send_idle_pct  = 0;  // sender gap chance, percent
    int  stall_pct      = 0;  // receiver stall chance, percent
    longint cycle_count = 0;

    always #5 aclk = ~aclk;

    rational_arith_reduce u_top (.*);

    // Sample both channels at the rising edge.
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (aresetn) begin
            if (s_tvalid && s_tready) sb.note_request(s_tuser, s_tdata);
            if (m_tvalid && m_tready) sb.check_result(m_tdata, m_tuser);
        end
        if (cycle_count > 64'd3000000) begin
            $display("FAIL rational_arith_reduce");
            $finish;
        end
    end

    // Receiver back-pressure, changed at the falling edge.
    always @(negedge aclk)
        m_tready <= ($urandom_range(99) >= stall_pct);

    // Send one request; random gaps before it, hold until taken.
    task automatic send_request(input logic [1:0] op, input logic [79:0] d);
        while ($urandom_range(99) < send_idle_pct) begin
            @(negedge aclk);
            s_tvalid <= 1'b0;
        end
        @(negedge aclk);
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= d;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
    endtask

    task automatic send_fields(input logic [1:0] op, input logic [15:0] a, input logic [15:0] b,
                               input logic [15:0] c, input logic [15:0] e,
                               input logic [15:0] w);
        send_request(op, {w, e, c, b, a});
    endtask

    // Small values keep GCD and non-overflow paths common; sometimes full range.
    function automatic logic [15:0] pick_field();
        case ($urandom_range(3))
            0: pick_field = 16'($urandom);
            1: pick_field = 16'($signed($urandom_range(40)) - 20);
            2: pick_field = $urandom_range(1) ? 16'h8000 : 16'h7fff;
            default: pick_field = 16'($signed($urandom_range(2000)) - 1000);
        endcase
    endfunction

    task automatic drain_results();
        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (sb.pending.size() != 0) @(posedge aclk);
    endtask

    task automatic random_phase(input int n, input int idle, input int stall);
        send_idle_pct = idle;
        stall_pct     = stall;
        repeat (n) begin
            send_fields(2'($urandom_range(3)), pick_field(), pick_field(), pick_field(),
                        pick_field(), pick_field());
        end
    endtask

    initial begin
        repeat (7) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // Directed: every opcode, zero denominators, zero result, extremes, overflow.
        send_fields(rar_pkg::OP_ADD, 16'd1, 16'd2, 16'd1, 16'd2, 16'd0);       // shared den
        send_fields(rar_pkg::OP_SUB, 16'd1, 16'd3, 16'd1, 16'd6, 16'd0);       // cross
        send_fields(rar_pkg::OP_MUL, -16'sd4, 16'd6, 16'd3, -16'sd8, 16'd0);
        send_fields(rar_pkg::OP_WHOLE, 16'hffff, 16'h0, 16'h0, 16'h0, 16'd5);
        send_fields(rar_pkg::OP_ADD, 16'd3, 16'd0, 16'd1, 16'd1, 16'd0);       // zero lhs den
        send_fields(rar_pkg::OP_MUL, 16'd3, 16'd1, 16'd1, 16'd0, 16'd0);       // zero rhs den
        send_fields(rar_pkg::OP_SUB, 16'd7, 16'd5, 16'd7, 16'd5, 16'd0);       // zero numerator
        send_fields(rar_pkg::OP_MUL, 16'h8000, 16'h7fff, 16'h8000, 16'h7ffd, 16'd0);
        send_fields(rar_pkg::OP_MUL, 16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h0);
        send_fields(rar_pkg::OP_ADD, 16'h7fff, 16'h8000, 16'h7fff, 16'h7fff, 16'hffff);
        send_fields(rar_pkg::OP_MUL, 16'h8000, 16'h0001, 16'h7fff, 16'h0001, 16'd0);
        send_fields(rar_pkg::OP_MUL, 16'h8000, 16'h0001, 16'h8000, 16'hffff, 16'd0);
        send_fields(rar_pkg::OP_MUL, 16'h0001, 16'h7fff, 16'h0001, 16'h7ffd, 16'd0);
        send_fields(rar_pkg::OP_WHOLE, 16'h0, 16'h0, 16'h0, 16'h0, 16'h7fff);
        // whole additions whose sums overflow; the stored fraction is left as it was
        repeat (8) send_fields(rar_pkg::OP_WHOLE, 16'h0, 16'h0, 16'h0, 16'h0, 16'h7fff);
        send_fields(rar_pkg::OP_WHOLE, 16'h0, 16'h0, 16'h0, 16'h0, 16'h8000);
        drain_results();

        random_phase(400, 0, 0);
        random_phase(350, 50, 0);
        drain_results();             // sender waits for every result
        random_phase(350, 0, 50);
        random_phase(400, 18, 18);
        drain_results();
        repeat (300) @(posedge aclk);

        if (sb.errors == 0 && sb.pending.size() == 0) begin
            $display("PASS rational_arith_reduce");
        end else begin
            $display("FAIL rational_arith_reduce");
        end
        $finish;
    end
endmodule
